FILE: design/fspa_pkg.sv
// Shared types and constants for the fixed slot pool allocator.
// No dependencies; every other file of the block imports this package.
package fspa_pkg;

  // Pool geometry
  localparam int MAX_SLOTS     = 1024;
  localparam int IDX_W         = $clog2(MAX_SLOTS);
  localparam int CNT_W         = IDX_W + 1;
  localparam int ADDR_W        = 32;
  localparam int POINTER_BYTES = 8;
  localparam int DEFAULT_ALIGN = 16;

  // Field and register widths
  localparam int REQ_W        = 16;
  localparam int SLOT_BYTES_W = 16;
  localparam int ALIGN_W      = 13;
  localparam int CAP_W        = 11;
  localparam int CFG_IDX_W    = 3;

  // Stride is at most slot bytes + alignment - 1, which fits 17 bits
  localparam int STRIDE_W = SLOT_BYTES_W + 1;
  localparam int EXT_W    = STRIDE_W + CNT_W;
  localparam int PROD_W   = STRIDE_W + IDX_W;
  localparam int STEP_W   = $clog2(ADDR_W) + 1;

  localparam logic [CNT_W-1:0]  HEAD_NONE        = CNT_W'(MAX_SLOTS);
  localparam logic [CNT_W-1:0]  TOTAL_MAX        = {CNT_W{1'b1}};
  localparam logic [STEP_W-1:0] DIV_STRIDE_STEPS = STEP_W'(STRIDE_W);
  localparam logic [STEP_W-1:0] DIV_OFFSET_STEPS = STEP_W'(ADDR_W);

  // Request actions
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGNMENT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_MODE  = 3'd4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_BAD_CONFIG   = 3'd2,
    ST_EXHAUSTED    = 3'd3,
    ST_INVALID_FREE = 3'd4
  } status_t;

  // Commands from the sequencer to the free list
  typedef struct packed {
    logic             start;
    logic             pop_head;
    logic             pop_untouched;
    logic             push;
    logic [IDX_W-1:0] push_idx;
  } fl_cmd_t;

  // Free list state seen by the sequencer
  typedef struct packed {
    logic             started;
    logic             head_valid;
    logic [IDX_W-1:0] head_idx;
    logic [CNT_W-1:0] untouched;
    logic [CNT_W-1:0] total;
  } fl_stat_t;

  // Divider control and status
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/fspa_if.sv
// Request and result channel interfaces for the fixed slot pool allocator.
// Depends on fspa_pkg.
interface fspa_in_if import fspa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] address;

  modport source(output valid, action, request_size, address, input ready);
  modport sink(input valid, action, request_size, address, output ready);
endinterface

interface fspa_out_if import fspa_pkg::*; ();
  logic              valid;
  logic              ready;
  status_t           status;
  logic [ADDR_W-1:0] slot_address;
  logic [IDX_W-1:0]  slot_index;
  logic [CNT_W-1:0]  slots_free;
  logic              fatal;

  modport source(output valid, status, slot_address, slot_index, slots_free, fatal,
                 input ready);
  modport sink(input valid, status, slot_address, slot_index, slots_free, fatal,
               output ready);
endinterface

FILE: design/fspa_div.sv
// Restoring divider, one quotient bit per cycle, shared by stride and offset math.
// Depends on fspa_pkg. Dividend is left aligned; steps gives its width.
module fspa_div import fspa_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  div_ctl_t            ctl,
  input  logic [ADDR_W-1:0]   dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output div_stat_t           stat,
  output logic [ADDR_W-1:0]   quotient,
  output logic [STRIDE_W-1:0] remainder
);

  logic [ADDR_W-1:0]   dvd_r;
  logic [ADDR_W-1:0]   quo_r;
  logic [STRIDE_W-1:0] rem_r;
  logic [STRIDE_W-1:0] dsr_r;
  logic [STEP_W-1:0]   cnt_r;
  logic                busy_r;
  logic                done_r;

  logic [STRIDE_W:0] shifted;
  logic [STRIDE_W:0] trial;
  logic              fits;

  // One trial subtraction per cycle
  assign shifted = {rem_r, dvd_r[ADDR_W-1]};
  assign trial   = shifted - {1'b0, dsr_r};
  assign fits    = (shifted >= {1'b0, dsr_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= busy_r && !ctl.start && (cnt_r == STEP_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ADDR_W-2:0], 1'b0};
      quo_r <= {quo_r[ADDR_W-2:0], fits};
      rem_r <= fits ? trial[STRIDE_W-1:0] : shifted[STRIDE_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: design/fspa_free_list.sv
// Free list store: link memory, head pointer, untouched counter, free count.
// Depends on fspa_pkg. Link memory reads are registered.
module fspa_free_list import fspa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  fl_cmd_t          cmd,
  input  logic [CNT_W-1:0] cap_lim,
  output fl_stat_t         stat
);

  logic [CNT_W-1:0] link_mem [MAX_SLOTS];
  logic [CNT_W-1:0] link_q_r;
  logic [CNT_W-1:0] head_r;
  logic [CNT_W-1:0] untouched_r;
  logic [CNT_W-1:0] total_r;
  logic             started_r;
  logic             pop_pend_r;

  // Link memory: push writes the old head, head is read every cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      link_mem[cmd.push_idx] <= head_r;
    end
    link_q_r <= link_mem[head_r[IDX_W-1:0]];
  end

  // Stack and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      head_r      <= HEAD_NONE;
      untouched_r <= '0;
      total_r     <= '0;
      pop_pend_r  <= 1'b0;
    end else begin
      pop_pend_r <= cmd.pop_head;
      if (cmd.start) begin
        started_r   <= 1'b1;
        untouched_r <= cap_lim;
        total_r     <= cap_lim;
        head_r      <= HEAD_NONE;
      end
      // head follows its link once the read data is back
      if (pop_pend_r) begin
        head_r <= link_q_r;
      end
      if (cmd.pop_untouched) begin
        untouched_r <= untouched_r - 1'b1;
      end
      if ((cmd.pop_head || cmd.pop_untouched) && total_r != '0) begin
        total_r <= total_r - 1'b1;
      end
      if (cmd.push) begin
        head_r <= {1'b0, cmd.push_idx};
        if (total_r != TOTAL_MAX) begin
          total_r <= total_r + 1'b1;
        end
      end
    end
  end

  assign stat.started    = started_r;
  assign stat.head_valid = (head_r < HEAD_NONE);
  assign stat.head_idx   = head_r[IDX_W-1:0];
  assign stat.untouched  = untouched_r;
  assign stat.total      = total_r;

endmodule

FILE: design/fixed_slot_pool_allocator.sv
// Top level of the fixed slot pool allocator: configuration, sequencer, result register.
// Depends on fspa_pkg, fspa_if, fspa_div and fspa_free_list.
//
// Usage:
//   in_ch  (sink)  : requests, action 0 allocates a slot, action 1 frees the slot
//                    at address. A request is taken when valid and ready are high.
//   out_ch (source): one result per request, held in an output register until
//                    the receiver takes it (valid and ready high).
//   cfg_*          : register writes (slot size, alignment, capacity, pool base,
//                    fail mode); the user makes them only while no request is in flight, the block does not check.
// Sequence: one request at a time. The divider first computes the stride (17
//   quotient bits) on every request, then the request is checked. A good allocate
//   pops a slot (waiting on the link read when it reuses a freed slot), multiplies
//   and adds; an oversize or bad-config allocate goes straight to the result, an
//   exhausted one after the pop. A free goes to the result before the pool starts
//   or after the range compare; in range it first divides the offset (32 quotient
//   bits). A new request is taken while the previous result still sits in the output
//   register.
// Reset: configuration returns to its defaults, the pool is not started and
//   reports zero free slots until the first good allocate. The link memory
//   needs no clearing pass.
// Receiver stall: a finished result waits in the sequencer until the output
//   register is free; no request is taken meanwhile.
module fixed_slot_pool_allocator import fspa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fspa_in_if.sink              in_ch,
  fspa_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SDIV  = 10'b0000000010,
    S_CHECK = 10'b0000000100,
    S_POP   = 10'b0000001000,
    S_POPW  = 10'b0000010000,
    S_AMUL  = 10'b0000100000,
    S_AADD  = 10'b0001000000,
    S_FCMP  = 10'b0010000000,
    S_FDIV  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  // Configuration registers
  logic [SLOT_BYTES_W-1:0] slot_bytes_r;
  logic [ALIGN_W-1:0]      alignment_r;
  logic [CAP_W-1:0]        capacity_r;
  logic [ADDR_W-1:0]       pool_base_r;
  logic                    fail_mode_r;

  // Sequencer state and working registers
  state_t            state_r;
  logic              act_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] addr_in_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [ADDR_W-1:0] offset_r;
  logic [EXT_W-1:0]  extent_r;
  logic [PROD_W-1:0] prod_r;
  logic [IDX_W-1:0]  idx_r;
  status_t           res_status_r;
  logic [ADDR_W-1:0] res_addr_r;
  logic [IDX_W-1:0]  res_idx_r;

  // Output register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_free_r;
  logic              out_fatal_r;

  // Derived values
  logic [ALIGN_W-1:0]      align_eff;
  logic [SLOT_BYTES_W-1:0] size_eff;
  logic [STRIDE_W-1:0]     round_sum;
  logic [CNT_W-1:0]        cap_lim;
  logic [2*ALIGN_W-1:0]    stride_prod;
  logic                    accept;
  logic                    out_free_slot;

  // Submodule connections
  div_ctl_t            div_ctl;
  div_stat_t           div_stat;
  logic [ADDR_W-1:0]   div_dividend;
  logic [STRIDE_W-1:0] div_divisor;
  logic [ADDR_W-1:0]   div_quo;
  logic [STRIDE_W-1:0] div_rem;
  fl_cmd_t             fl_cmd;
  fl_stat_t            fl_stat;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r <= SLOT_BYTES_W'(64);
      alignment_r  <= ALIGN_W'(16);
      capacity_r   <= CAP_W'(1024);
      pool_base_r  <= '0;
      fail_mode_r  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_BYTES: slot_bytes_r <= cfg_data[SLOT_BYTES_W-1:0];
        CFG_ALIGNMENT:  alignment_r  <= cfg_data[ALIGN_W-1:0];
        CFG_CAPACITY:   capacity_r   <= cfg_data[CAP_W-1:0];
        CFG_POOL_BASE:  pool_base_r  <= cfg_data;
        CFG_FAIL_MODE:  fail_mode_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stride inputs: size raised to a pointer, alignment raised to the default
  assign align_eff = (alignment_r < ALIGN_W'(DEFAULT_ALIGN)) ?
                     ALIGN_W'(DEFAULT_ALIGN) : alignment_r;
  assign size_eff  = (slot_bytes_r < SLOT_BYTES_W'(POINTER_BYTES)) ?
                     SLOT_BYTES_W'(POINTER_BYTES) : slot_bytes_r;
  assign round_sum = {1'b0, size_eff} + STRIDE_W'(align_eff) - 1'b1;
  assign cap_lim   = (capacity_r > CAP_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) :
                     CNT_W'(capacity_r);
  // quotient of the rounding divide is below 2^13
  assign stride_prod = div_quo[ALIGN_W-1:0] * align_eff;

  assign accept        = in_ch.valid && in_ch.ready;
  assign out_free_slot = !out_valid_r || out_ch.ready;

  // Divider and free list command decode
  always_comb begin
    div_ctl      = '0;
    div_dividend = {round_sum, {(ADDR_W-STRIDE_W){1'b0}}};
    div_divisor  = STRIDE_W'(align_eff);
    fl_cmd       = '0;
    fl_cmd.push_idx = div_quo[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        div_ctl.start = accept;
        div_ctl.steps = DIV_STRIDE_STEPS;
      end
      S_CHECK: begin
        fl_cmd.start = (act_r == ACT_ALLOC) && (req_r <= slot_bytes_r) &&
                       (capacity_r != '0) && (slot_bytes_r != '0) && !fl_stat.started;
      end
      S_POP: begin
        fl_cmd.pop_head      = fl_stat.head_valid;
        fl_cmd.pop_untouched = !fl_stat.head_valid && (fl_stat.untouched != '0);
      end
      S_FCMP: begin
        div_dividend  = offset_r;
        div_divisor   = stride_r;
        div_ctl.start = (offset_r < ADDR_W'(extent_r));
        div_ctl.steps = DIV_OFFSET_STEPS;
      end
      S_FDIV: begin
        fl_cmd.push = div_stat.done && (div_rem == '0);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  if (accept) state_r <= S_SDIV;
        S_SDIV:  if (div_stat.done) state_r <= S_CHECK;
        S_CHECK: begin
          if (act_r == ACT_ALLOC) begin
            if (req_r > slot_bytes_r || capacity_r == '0 || slot_bytes_r == '0) begin
              state_r <= S_OUT;
            end else begin
              state_r <= S_POP;
            end
          end else begin
            state_r <= fl_stat.started ? S_FCMP : S_OUT;
          end
        end
        S_POP: begin
          if (fl_stat.head_valid) begin
            state_r <= S_POPW;
          end else if (fl_stat.untouched != '0) begin
            state_r <= S_AMUL;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_POPW:  state_r <= S_AMUL;
        S_AMUL:  state_r <= S_AADD;
        S_AADD:  state_r <= S_OUT;
        S_FCMP:  state_r <= (offset_r < ADDR_W'(extent_r)) ? S_FDIV : S_OUT;
        S_FDIV:  if (div_stat.done) state_r <= S_OUT;
        S_OUT:   if (out_free_slot) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers and pending result
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_r     <= in_ch.action;
          req_r     <= in_ch.request_size;
          addr_in_r <= in_ch.address;
        end
      end
      S_SDIV: begin
        if (div_stat.done) begin
          stride_r <= stride_prod[STRIDE_W-1:0];
        end
      end
      S_CHECK: begin
        res_addr_r <= '0;
        res_idx_r  <= '0;
        offset_r   <= addr_in_r - pool_base_r;
        extent_r   <= stride_r * cap_lim;
        if (act_r == ACT_ALLOC) begin
          if (req_r > slot_bytes_r) begin
            res_status_r <= ST_TOO_LARGE;
          end else if (capacity_r == '0 || slot_bytes_r == '0) begin
            res_status_r <= ST_BAD_CONFIG;
          end
        end else if (!fl_stat.started) begin
          res_status_r <= ST_INVALID_FREE;
        end
      end
      S_POP: begin
        if (fl_stat.head_valid) begin
          idx_r <= fl_stat.head_idx;
        end else if (fl_stat.untouched != '0) begin
          idx_r <= IDX_W'(fl_stat.untouched - 1'b1);
        end else begin
          res_status_r <= ST_EXHAUSTED;
        end
      end
      S_AMUL: prod_r <= idx_r * stride_r;
      S_AADD: begin
        res_status_r <= ST_OK;
        res_addr_r   <= pool_base_r + ADDR_W'(prod_r);
        res_idx_r    <= idx_r;
      end
      S_FCMP: begin
        if (offset_r >= ADDR_W'(extent_r)) begin
          res_status_r <= ST_INVALID_FREE;
        end
      end
      S_FDIV: begin
        if (div_stat.done) begin
          if (div_rem == '0) begin
            res_status_r <= ST_OK;
            res_idx_r    <= div_quo[IDX_W-1:0];
          end else begin
            res_status_r <= ST_INVALID_FREE;
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && out_free_slot) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free_slot) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_idx_r    <= res_idx_r;
      out_free_r   <= fl_stat.total;
      out_fatal_r  <= (res_status_r != ST_OK) && fail_mode_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.slot_address = out_addr_r;
  assign out_ch.slot_index   = out_idx_r;
  assign out_ch.slots_free   = out_free_r;
  assign out_ch.fatal        = out_fatal_r;

  fspa_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  fspa_free_list u_free_list (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fl_cmd),
    .cap_lim (cap_lim),
    .stat    (fl_stat)
  );

endmodule
